[hw/rtl/bfa_pkg.sv]
// Package with the shared constants, types and helper function of the bitmap allocator.
`timescale 1ns / 1ps

package bfa_pkg;

    localparam int MAP_BITS  = 8192;
    localparam int WORD_BITS = (MAP_BITS < 64) ? MAP_BITS : 64;
    localparam int WORDS     = MAP_BITS / WORD_BITS;
    localparam int WB        = $clog2(WORD_BITS);
    localparam int WORD_AW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int RAM_AW    = WORD_AW + 1;
    localparam int RAM_DEPTH = 2 ** RAM_AW;
    localparam int IDX_W     = $clog2(MAP_BITS);
    localparam int XW        = (IDX_W + 1 > 14) ? IDX_W + 1 : 14;

    localparam logic [13:0] LIMIT_RST = 14'(8192);
    localparam logic [13:0] USED_MAX  = 14'h3FFF;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;
    localparam logic POOL_INODE = 1'b0;
    localparam logic POOL_BLOCK = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    localparam logic REG_INODE_LIMIT = 1'b0;
    localparam logic REG_BLOCK_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FREE_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic          found;
        logic          done;
        logic [WB-1:0] pos;
        logic [XW-1:0] grant;
    } scan_t;

    function automatic logic [13:0] eff_limit(input logic [13:0] lim);
        if (32'(lim) > MAP_BITS) begin
            return 14'(MAP_BITS);
        end
        return lim;
    endfunction

endpackage

[hw/rtl/bfa_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module bfa_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/bfa_scan.sv]
// Lowest-clear-bit search over one bitmap word, checked against the pool limit.
`timescale 1ns / 1ps

module bfa_scan
    import bfa_pkg::*;
(
    input  logic [WORD_BITS-1:0] word,
    input  logic [WORD_AW-1:0]   word_idx,
    input  logic [13:0]          limit,
    output scan_t                res
);

    logic [WORD_BITS-1:0] zeros;
    logic [WORD_BITS-1:0] lowest;
    logic [WB-1:0]        pos;
    logic [XW-1:0]        base;
    logic [XW-1:0]        idx;
    logic [XW-1:0]        lim;
    logic [XW-1:0]        next_base;
    logic                 any_zero;
    logic                 hit;

    always_comb begin
        zeros  = ~word;
        lowest = zeros & (~zeros + WORD_BITS'(1));
        pos    = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (lowest[j]) begin
                pos = pos | WB'(j);
            end
        end
        base      = XW'(word_idx) << WB;
        idx       = base + XW'(pos);
        lim       = XW'(limit);
        next_base = base + XW'(WORD_BITS);
        any_zero  = |zeros;
        hit       = any_zero && (idx < lim);

        res.found = hit;
        res.done  = hit || any_zero || (next_base >= lim);
        res.pos   = pos;
        res.grant = idx + XW'(1);
    end

endmodule

[hw/rtl/bitmap_first_fit_allocator.sv]
// Top level of the two-pool first-free bitmap allocator with its APB register port.
`timescale 1ns / 1ps

// Each pool's bitmap is kept in one shared RAM as 64-bit words, and one search unit
// finds the lowest clear bit of a word per cycle. After reset the block runs a
// clearing pass over all 256 RAM words, one word per cycle, and takes no beat until it
// ends; register writes are taken throughout. An allocate reads words from the lowest
// up until it finds its free bit or reaches the pool limit; at most 128 words are
// searched, set by the pool limit and how full the low end of the bitmap is. A free
// does a read-modify-write of one word, and a rejected number goes straight to the
// result. A finished result sits in the output register, so the next beat is accepted
// while it waits to be taken.

module bitmap_first_fit_allocator
    import bfa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [13:0] number
    input  logic [1:0]  s_tuser,   // [0] func, [1] pool

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [13:0] granted, [27:14] free_left
    output logic [1:0]  m_tuser,   // [1:0] status

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    state_t               state_reg, state_next;
    logic [RAM_AW-1:0]    clr_reg, clr_next;
    logic [WORD_AW-1:0]   rd_word_reg, rd_word_next;
    logic [WORD_AW-1:0]   exam_word_reg, exam_word_next;
    logic                 pool_reg, pool_next;
    logic                 func_reg, func_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [13:0]          granted_reg, granted_next;
    logic [1:0]           status_reg, status_next;
    logic [13:0]          inode_used_reg, inode_used_next;
    logic [13:0]          block_used_reg, block_used_next;
    logic [13:0]          inode_limit_reg, block_limit_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [31:0]          m_tdata_reg, m_tdata_next;
    logic [1:0]           m_tuser_reg, m_tuser_next;

    logic                 ram_we;
    logic [RAM_AW-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [RAM_AW-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    scan_t                scan_res;

    logic                 in_pool;
    logic [13:0]          in_number;
    logic [13:0]          in_limit;
    logic [IDX_W-1:0]     in_idx;
    logic [13:0]          cur_limit;
    logic [13:0]          cur_used;
    logic [13:0]          free_left;
    logic                 cfg_write;

    bfa_ram #(
        .DATA_W (WORD_BITS),
        .DEPTH  (RAM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bfa_scan u_scan (
        .word     (ram_rdata),
        .word_idx (exam_word_reg),
        .limit    (cur_limit),
        .res      (scan_res)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_BLOCK_LIMIT) ? {18'd0, block_limit_reg}
                                                     : {18'd0, inode_limit_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inode_limit_reg <= LIMIT_RST;
            block_limit_reg <= LIMIT_RST;
        end else if (cfg_write) begin
            if (paddr[2] == REG_INODE_LIMIT) begin
                inode_limit_reg <= pwdata[13:0];
            end else begin
                block_limit_reg <= pwdata[13:0];
            end
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign in_pool   = s_tuser[1];
    assign in_number = s_tdata[13:0];
    assign in_limit  = eff_limit((in_pool == POOL_BLOCK) ? block_limit_reg : inode_limit_reg);
    assign in_idx    = IDX_W'(in_number - 14'd1);
    assign cur_limit = eff_limit((pool_reg == POOL_BLOCK) ? block_limit_reg
                                                          : inode_limit_reg);
    assign cur_used  = (pool_reg == POOL_BLOCK) ? block_used_reg : inode_used_reg;
    assign free_left = (cur_limit > cur_used) ? (cur_limit - cur_used) : 14'd0;

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        rd_word_next    = rd_word_reg;
        exam_word_next  = exam_word_reg;
        pool_next       = pool_reg;
        func_next       = func_reg;
        idx_next        = idx_reg;
        granted_next    = granted_reg;
        status_next     = status_reg;
        inode_used_next = inode_used_reg;
        block_used_next = block_used_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        ram_we          = 1'b0;
        ram_waddr       = {pool_reg, exam_word_reg};
        ram_wdata       = '0;
        ram_raddr       = {pool_reg, rd_word_reg};

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + RAM_AW'(1);
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next = s_tuser[0];
                    pool_next = in_pool;
                    if (s_tuser[0] == FUNC_ALLOC) begin
                        ram_raddr      = {in_pool, WORD_AW'(0)};
                        rd_word_next   = WORD_AW'(1);
                        exam_word_next = '0;
                        state_next     = ST_SCAN;
                    end else if (in_number == 14'd0 || in_number > in_limit) begin
                        status_next  = STAT_RANGE;
                        granted_next = 14'd0;
                        state_next   = ST_DONE;
                    end else begin
                        ram_raddr  = {in_pool, WORD_AW'(in_idx >> WB)};
                        idx_next   = in_idx;
                        state_next = ST_FREE_WR;
                    end
                end
            end
            ST_SCAN: begin
                exam_word_next = rd_word_reg;
                rd_word_next   = rd_word_reg + WORD_AW'(1);
                if (scan_res.done) begin
                    state_next = ST_DONE;
                    if (scan_res.found) begin
                        ram_we       = 1'b1;
                        ram_wdata    = ram_rdata | (WORD_BITS'(1) << scan_res.pos);
                        status_next  = STAT_OK;
                        granted_next = 14'(scan_res.grant);
                        if (pool_reg == POOL_BLOCK) begin
                            if (block_used_reg != USED_MAX) begin
                                block_used_next = block_used_reg + 14'd1;
                            end
                        end else if (inode_used_reg != USED_MAX) begin
                            inode_used_next = inode_used_reg + 14'd1;
                        end
                    end else begin
                        status_next  = STAT_FULL;
                        granted_next = 14'd0;
                    end
                end
            end
            ST_FREE_WR: begin
                ram_we       = 1'b1;
                ram_waddr    = {pool_reg, WORD_AW'(idx_reg >> WB)};
                ram_wdata    = ram_rdata & ~(WORD_BITS'(1) << idx_reg[WB-1:0]);
                status_next  = STAT_OK;
                granted_next = 14'd0;
                state_next   = ST_DONE;
                if (pool_reg == POOL_BLOCK) begin
                    if (block_used_reg != 14'd0) begin
                        block_used_next = block_used_reg - 14'd1;
                    end
                end else if (inode_used_reg != 14'd0) begin
                    inode_used_next = inode_used_reg - 14'd1;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'd0, free_left, granted_reg};
                    m_tuser_next  = status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            inode_used_reg <= '0;
            block_used_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            inode_used_reg <= inode_used_next;
            block_used_reg <= block_used_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        rd_word_reg   <= rd_word_next;
        exam_word_reg <= exam_word_next;
        pool_reg      <= pool_next;
        func_reg      <= func_next;
        idx_reg       <= idx_next;
        granted_reg   <= granted_next;
        status_reg    <= status_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    a_busy_after_beat: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready
    ) else $error("Allocator accepted a beat while still busy.");

    a_scan_write_on_hit: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && ram_we) |-> scan_res.found
    ) else $error("Bitmap written during search without a free bit.");

    a_grant_nonzero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && func_reg == FUNC_ALLOC && status_reg == STAT_OK)
            |-> (granted_reg != 14'd0)
    ) else $error("Successful allocate reported number zero.");

endmodule
